// ===== src/heightmap_voxel_face_emitter_macros.svh =====
// Assertion macros used by the checker file of the face emitter.
`ifndef HEIGHTMAP_VOXEL_FACE_EMITTER_MACROS_SVH
`define HEIGHTMAP_VOXEL_FACE_EMITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVFE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HVFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hvfe_pkg.sv =====
// Types, constants and helpers shared by the voxel face emitter.
package hvfe_pkg;

   localparam int PartSizeDefault = 16;

   localparam int HeightW = 4;
   localparam int CellW   = 5;
   localparam int DirW    = 3;
   localparam int VertW   = 16;

   localparam logic [HeightW-1:0] MaxHeight = 4'd15;
   localparam logic [VertW-1:0]   VertStep  = 16'd4;

   typedef enum logic [DirW-1:0] {
      DIR_TOP    = 3'd0,
      DIR_BOTTOM = 3'd1,
      DIR_POS_X  = 3'd2,
      DIR_NEG_X  = 3'd3,
      DIR_POS_Z  = 3'd4,
      DIR_NEG_Z  = 3'd5
   } face_dir_type;

   // Side faces in the order they are emitted.
   typedef enum logic [1:0] {
      SIDE_NEG_X = 2'd0,
      SIDE_POS_X = 2'd1,
      SIDE_NEG_Z = 2'd2,
      SIDE_POS_Z = 2'd3
   } side_type;

   typedef struct packed {
      logic     accept;
      logic     issue;
      logic     top;
      side_type side;
      logic     load_y;
      side_type load_side;
      logic     inc_y;
      logic     last;
   } hvfe_cmd_type;

   typedef struct packed {
      logic       emit_now;
      logic [3:0] has;
      logic       y_done;
      logic       slot_free;
   } hvfe_status_type;

   function automatic face_dir_type side_dir(input side_type side);
      face_dir_type dir;
      unique case (side)
         SIDE_NEG_X: dir = DIR_NEG_X;
         SIDE_POS_X: dir = DIR_POS_X;
         SIDE_NEG_Z: dir = DIR_NEG_Z;
         SIDE_POS_Z: dir = DIR_POS_Z;
         default:    dir = DIR_TOP;
      endcase
      return dir;
   endfunction

endpackage

// ===== src/hvfe_if.sv =====
// Valid/ready channel interfaces for the sample input and the face output.
interface hvfe_req_if import hvfe_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [HeightW-1:0] column_height;
   logic               new_part;

   modport source (output valid, output column_height, output new_part, input ready);
   modport sink   (input valid, input column_height, input new_part, output ready);
endinterface

interface hvfe_rsp_if import hvfe_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [CellW-1:0]   cell_x;
   logic [HeightW-1:0] cell_y;
   logic [CellW-1:0]   cell_z;
   logic [DirW-1:0]    face_dir;
   logic [VertW-1:0]   base_vertex;
   logic               last_face;

   modport source (output valid, output cell_x, output cell_y, output cell_z,
                   output face_dir, output base_vertex, output last_face, input ready);
   modport sink   (input valid, input cell_x, input cell_y, input cell_z,
                   input face_dir, input base_vertex, input last_face, output ready);
endinterface

// ===== src/hvfe_ctrl.sv =====
// Controller that sequences the top face and the side face runs of one column.
module hvfe_ctrl import hvfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hvfe_status_type status,
   output hvfe_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TOP,
      ST_SIDE
   } state_type;

   state_type state_ff;
   side_type  side_ff;

   logic [3:0] after_mask;
   logic [3:0] cand;
   logic       found;
   side_type   next_side;

   // First side after the current one (from the top face, any side) that still has faces to emit.
   always_comb begin
      after_mask = (state_ff == ST_SIDE) ? 4'(4'b1110 << side_ff) : 4'b1111;
      cand       = status.has & after_mask;
      found      = 1'b0;
      next_side  = SIDE_NEG_X;
      for (int i = 0; i < 4; i++) begin
         if (cand[i] && !found) begin
            found     = 1'b1;
            next_side = side_type'(i);
         end
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.side  = side_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_TOP: begin
            if (status.slot_free) begin
               cmd.issue     = 1'b1;
               cmd.top       = 1'b1;
               cmd.load_y    = found;
               cmd.load_side = next_side;
               cmd.last      = !found;
            end
         end
         ST_SIDE: begin
            if (status.slot_free) begin
               cmd.issue = 1'b1;
               if (status.y_done) begin
                  cmd.load_y    = found;
                  cmd.load_side = next_side;
                  cmd.last      = !found;
               end else begin
                  cmd.inc_y = 1'b1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= SIDE_NEG_X;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.accept && status.emit_now) begin
                  state_ff <= ST_TOP;
               end
            end
            ST_TOP, ST_SIDE: begin
               if (cmd.issue && cmd.load_y) begin
                  state_ff <= ST_SIDE;
                  side_ff  <= cmd.load_side;
               end else if (cmd.issue && cmd.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/hvfe_datapath.sv =====
// Datapath: row shift line, grid position, neighbor capture and face output register.
module hvfe_datapath import hvfe_pkg::*; #(
   parameter int INTERIOR_SIZE = PartSizeDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  hvfe_cmd_type       cmd,
   output hvfe_status_type    status,
   input  logic [HeightW-1:0] column_height,
   input  logic               new_part,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [CellW-1:0]   cell_x,
   output logic [HeightW-1:0] cell_y,
   output logic [CellW-1:0]   cell_z,
   output logic [DirW-1:0]    face_dir,
   output logic [VertW-1:0]   base_vertex,
   output logic               last_face
);

   localparam int GridDim = INTERIOR_SIZE + 2;
   localparam int CntW    = $clog2(GridDim);
   localparam int LineLen = 2 * GridDim;

   // Two rows of samples; tap GridDim-1 is the column being meshed.
   logic [HeightW-1:0] line_ff [LineLen];

   logic [CntW-1:0]    col_ff;
   logic [CntW-1:0]    row_ff;
   logic [VertW-1:0]   vtx_ff;
   logic               rsp_valid_ff;

   logic [HeightW-1:0] cur_ff;
   logic [HeightW-1:0] nb_ff [4];
   logic [3:0]         has_ff;
   logic [CntW-1:0]    x_ff;
   logic [CntW-1:0]    z_ff;
   logic [HeightW-1:0] y_ff;

   logic [CellW-1:0]   cell_x_ff;
   logic [HeightW-1:0] cell_y_ff;
   logic [CellW-1:0]   cell_z_ff;
   logic [DirW-1:0]    face_dir_ff;
   logic [VertW-1:0]   base_vertex_ff;
   logic               last_face_ff;

   logic [HeightW-1:0] hin_sat;
   logic [CntW-1:0]    c_cur;
   logic [CntW-1:0]    r_cur;
   logic [HeightW-1:0] cur_tap;
   logic [HeightW-1:0] nb_tap [4];

   always_comb begin
      hin_sat = (column_height > MaxHeight) ? MaxHeight : column_height;
      c_cur   = new_part ? '0 : col_ff;
      r_cur   = new_part ? '0 : row_ff;
      cur_tap = line_ff[GridDim-1];
      nb_tap[SIDE_NEG_X] = line_ff[GridDim];
      nb_tap[SIDE_POS_X] = line_ff[GridDim-2];
      nb_tap[SIDE_NEG_Z] = line_ff[LineLen-1];
      nb_tap[SIDE_POS_Z] = hin_sat;

      status.emit_now  = (r_cur >= CntW'(2)) && (c_cur != '0)
                         && (c_cur <= CntW'(INTERIOR_SIZE));
      status.has       = has_ff;
      status.y_done    = (y_ff == cur_ff);
      status.slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (c_cur == CntW'(GridDim - 1)) begin
               col_ff <= '0;
               row_ff <= (r_cur == CntW'(GridDim - 1)) ? '0 : r_cur + 1'b1;
            end else begin
               col_ff <= c_cur + 1'b1;
               row_ff <= r_cur;
            end
            if (new_part) begin
               vtx_ff <= '0;
            end
         end
         if (cmd.issue) begin
            vtx_ff       <= vtx_ff + VertStep;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         line_ff[0] <= hin_sat;
         for (int i = 1; i < LineLen; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
         cur_ff <= cur_tap;
         for (int s = 0; s < 4; s++) begin
            nb_ff[s]  <= nb_tap[s];
            has_ff[s] <= (cur_tap > nb_tap[s]);
         end
         x_ff <= c_cur;
         z_ff <= r_cur - 1'b1;
      end
      if (cmd.load_y) begin
         y_ff <= nb_ff[cmd.load_side] + 1'b1;
      end else if (cmd.inc_y) begin
         y_ff <= y_ff + 1'b1;
      end
      if (cmd.issue) begin
         cell_x_ff      <= CellW'(x_ff);
         cell_z_ff      <= CellW'(z_ff);
         cell_y_ff      <= cmd.top ? cur_ff : y_ff;
         face_dir_ff    <= cmd.top ? DIR_TOP : side_dir(cmd.side);
         base_vertex_ff <= vtx_ff;
         last_face_ff   <= cmd.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cell_x      = cell_x_ff;
   assign cell_y      = cell_y_ff;
   assign cell_z      = cell_z_ff;
   assign face_dir    = face_dir_ff;
   assign base_vertex = base_vertex_ff;
   assign last_face   = last_face_ff;

endmodule

// ===== src/heightmap_voxel_face_emitter.sv =====
// Top level of the heightmap voxel face emitter.
// A sample that makes no faces (border ring, first two rows) leaves the controller idle.
// An interior column is accepted and then gives 1 to 61 faces through the single output register,
// which receives one face per cycle while the output is not stalled.
// The transfer starts the top state, which registers the first face once the output slot is free.
// Reset clears the position, vertex index, controller and output valid; row samples are not reset.
module heightmap_voxel_face_emitter import hvfe_pkg::*; #(
   parameter int INTERIOR_SIZE = PartSizeDefault
) (
   input  logic       clock,
   input  logic       reset,
   hvfe_req_if.sink   req_chan,
   hvfe_rsp_if.source rsp_chan
);

   hvfe_cmd_type    cmd;
   hvfe_status_type status;

   hvfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hvfe_datapath #(
      .INTERIOR_SIZE (INTERIOR_SIZE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .column_height (req_chan.column_height),
      .new_part      (req_chan.new_part),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .cell_x        (rsp_chan.cell_x),
      .cell_y        (rsp_chan.cell_y),
      .cell_z        (rsp_chan.cell_z),
      .face_dir      (rsp_chan.face_dir),
      .base_vertex   (rsp_chan.base_vertex),
      .last_face     (rsp_chan.last_face)
   );

endmodule

// ===== src/hvfe_checker.sv =====
// Port-level checker for the face emitter and its bind to the top level.
`include "heightmap_voxel_face_emitter_macros.svh"

module hvfe_checker import hvfe_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [CellW-1:0]   cell_x,
   input logic [HeightW-1:0] cell_y,
   input logic [CellW-1:0]   cell_z,
   input logic [DirW-1:0]    face_dir,
   input logic [VertW-1:0]   base_vertex,
   input logic               last_face
);

   `HVFE_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")
   `HVFE_ASSERT_NEXT(a_rsp_payload_hold, clock, reset, rsp_valid && !rsp_ready, $stable(cell_x) && $stable(cell_y) && $stable(cell_z) && $stable(face_dir) && $stable(base_vertex) && $stable(last_face), "rsp payload changed while stalled")
   `HVFE_ASSERT_SAME(a_face_dir_legal, clock, reset, rsp_valid, face_dir == DIR_TOP || face_dir == DIR_POS_X || face_dir == DIR_NEG_X || face_dir == DIR_POS_Z || face_dir == DIR_NEG_Z, "illegal face direction")
   `HVFE_ASSERT_SAME(a_busy_mid_column, clock, reset, rsp_valid && !last_face, !req_ready, "sample input open while faces of a column remain")

endmodule

bind heightmap_voxel_face_emitter hvfe_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .cell_x      (rsp_chan.cell_x),
   .cell_y      (rsp_chan.cell_y),
   .cell_z      (rsp_chan.cell_z),
   .face_dir    (rsp_chan.face_dir),
   .base_vertex (rsp_chan.base_vertex),
   .last_face   (rsp_chan.last_face)
);

// ===== bench/heightmap_voxel_face_emitter_tb.sv =====
// Self-checking testbench for the heightmap voxel face emitter.
`timescale 1ns / 100ps

module heightmap_voxel_face_emitter_tb;
   import hvfe_pkg::*;

   localparam int PartSize    = PartSizeDefault;
   localparam int GridDim     = PartSize + 2;
   localparam int CycleLimit  = 200_000;
   localparam int DrainCycles = 20;
   localparam int ReportMax   = 10;
   localparam int PhaseItems  = 25;

   typedef enum {
      PACE_FULL,
      PACE_SRC_GAPS,
      PACE_SINK_STALLS,
      PACE_BOTH
   } pace_mode_type;

   typedef enum {
      RELIEF_CHECKER,
      RELIEF_RANDOM
   } relief_type;

   typedef struct packed {
      logic [HeightW-1:0] height;
      logic               new_part;
   } sample_type;

   typedef struct packed {
      logic [CellW-1:0]   cell_x;
      logic [HeightW-1:0] cell_y;
      logic [CellW-1:0]   cell_z;
      logic [DirW-1:0]    face_dir;
      logic [VertW-1:0]   base_vertex;
      logic               last_face;
   } face_type;

   logic clock;
   logic reset;

   hvfe_req_if req_if ();
   hvfe_rsp_if rsp_if ();

   heightmap_voxel_face_emitter #(
      .INTERIOR_SIZE(PartSize)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   sample_type    sample_queue[$];
   face_type      face_queue[$];
   face_type      column_faces[$];
   pace_mode_type pace_mode;
   bit            sample_taken;
   int            cycle_count;
   int            failures;
   int            scan_pos;

   // Shadow copy of the block's row stores and scan position.
   logic [HeightW-1:0] above_row  [0:GridDim-1];
   logic [HeightW-1:0] center_row [0:GridDim-1];
   logic [CellW-1:0]   col_cnt;
   logic [CellW-1:0]   row_cnt;
   logic [VertW-1:0]   vert_idx;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_face(input logic [CellW-1:0] x, input int y,
                                      input logic [CellW-1:0] z, input face_dir_type dir);
      face_type f;
      f.cell_x      = x;
      f.cell_y      = y[HeightW-1:0];
      f.cell_z      = z;
      f.face_dir    = dir;
      f.base_vertex = vert_idx;
      f.last_face   = 1'b0;
      column_faces.insert(column_faces.size(), f);
      vert_idx = vert_idx + VertStep;
   endfunction

   // One face per level above the neighbor, lowest level first.
   function automatic void add_side(input logic [CellW-1:0] x, input logic [CellW-1:0] z,
                                    input logic [HeightW-1:0] h,
                                    input logic [HeightW-1:0] nh, input face_dir_type dir);
      for (int y = int'(nh) + 1; y <= int'(h); y++) begin
         queue_face(x, y, z, dir);
      end
   endfunction

   function automatic void predict_column(input logic [HeightW-1:0] height,
                                          input logic new_part);
      logic [CellW-1:0]   c;
      logic [CellW-1:0]   r;
      logic [CellW-1:0]   z;
      logic [HeightW-1:0] cur;
      logic [HeightW-1:0] minus_x;
      logic [HeightW-1:0] plus_x;
      logic [HeightW-1:0] minus_z;
      if (new_part) begin
         col_cnt  = '0;
         row_cnt  = '0;
         vert_idx = '0;
      end
      c       = col_cnt;
      r       = row_cnt;
      cur     = center_row[c];
      minus_z = above_row[c];
      plus_x  = (int'(c) + 1 < GridDim) ? center_row[c + 1] : '0;
      minus_x = (c > 0) ? above_row[c - 1] : '0;
      above_row[c]  = cur;
      center_row[c] = (height > MaxHeight) ? MaxHeight : height;
      if (r >= 2 && c >= 1 && int'(c) <= PartSize) begin
         z = r - 1'b1;
         column_faces.delete();
         queue_face(c, int'(cur), z, DIR_TOP);
         add_side(c, z, cur, minus_x, DIR_NEG_X);
         add_side(c, z, cur, plus_x, DIR_POS_X);
         add_side(c, z, cur, minus_z, DIR_NEG_Z);
         add_side(c, z, cur, center_row[c], DIR_POS_Z);
         column_faces[column_faces.size() - 1].last_face = 1'b1;
         foreach (column_faces[i]) face_queue.insert(face_queue.size(), column_faces[i]);
      end
      col_cnt = c + 1'b1;
      if (int'(col_cnt) >= GridDim) begin
         col_cnt = '0;
         row_cnt = r + 1'b1;
         if (int'(row_cnt) >= GridDim) row_cnt = '0;
      end
   endfunction

   function automatic void check_face();
      face_type got;
      face_type want;
      got.cell_x      = rsp_if.cell_x;
      got.cell_y      = rsp_if.cell_y;
      got.cell_z      = rsp_if.cell_z;
      got.face_dir    = rsp_if.face_dir;
      got.base_vertex = rsp_if.base_vertex;
      got.last_face   = rsp_if.last_face;
      if (face_queue.size() == 0) begin
         failures++;
         if (failures <= ReportMax)
            $display("unexpected face: x=%0d y=%0d z=%0d dir=%0d vert=%0d last=%0d",
                     got.cell_x, got.cell_y, got.cell_z, got.face_dir,
                     got.base_vertex, got.last_face);
      end else begin
         want = face_queue.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= ReportMax)
               $display({"face mismatch: exp x=%0d y=%0d z=%0d dir=%0d vert=%0d last=%0d",
                         " got x=%0d y=%0d z=%0d dir=%0d vert=%0d last=%0d"},
                        want.cell_x, want.cell_y, want.cell_z, want.face_dir,
                        want.base_vertex, want.last_face,
                        got.cell_x, got.cell_y, got.cell_z, got.face_dir,
                        got.base_vertex, got.last_face);
         end
      end
   endfunction

   function automatic bit sender_rests();
      case (pace_mode)
         PACE_SRC_GAPS: return $urandom_range(99, 0) < 58;
         PACE_BOTH:     return $urandom_range(99, 0) < 9;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (pace_mode)
         PACE_SINK_STALLS: return $urandom_range(99, 0) < 58;
         PACE_BOTH:        return $urandom_range(99, 0) < 9;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic logic [HeightW-1:0] random_height();
      case ($urandom_range(9, 0))
         0, 1:    return '0;
         2, 3:    return MaxHeight;
         default: return HeightW'($urandom_range(15, 0));
      endcase
   endfunction

   function automatic void add_sample(input logic [HeightW-1:0] height, input logic new_part);
      sample_type s;
      s.height   = height;
      s.new_part = new_part;
      sample_queue.insert(sample_queue.size(), s);
   endfunction

   // A stretch of the scan starting at grid position first; the checker relief puts
   // tall columns next to low ones so that most sides are tall.
   function automatic void add_scan(input relief_type relief, input int first,
                                    input int count, input bit restart);
      logic [HeightW-1:0] h;
      int                 x;
      int                 z;
      for (int i = 0; i < count; i++) begin
         x = (first + i) % GridDim;
         z = ((first + i) / GridDim) % GridDim;
         if (relief == RELIEF_RANDOM)
            h = random_height();
         else if ((x + z) % 2 == 1)
            h = ($urandom_range(9, 0) == 0) ? HeightW'($urandom_range(15, 12)) : MaxHeight;
         else
            h = HeightW'($urandom_range(2, 0));
         add_sample(h, restart && i == 0);
      end
   endfunction

   // Channel driver: a pending input transfer holds its payload until it is taken; output ready follows the pacing.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || sample_taken) begin
            if (sample_queue.size() != 0 && !sender_rests()) begin
               req_if.valid         <= 1'b1;
               req_if.column_height <= sample_queue[0].height;
               req_if.new_part      <= sample_queue[0].new_part;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         sample_taken = 1'b0;
         rsp_if.ready <= !receiver_stalls();
      end
   end

   // Monitor: checks faces first, then predicts the faces of an accepted sample.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) check_face();
         if (req_if.valid && req_if.ready) begin
            predict_column(req_if.column_height, req_if.new_part);
            void'(sample_queue.pop_front());
            sample_taken = 1'b1;
         end
      end
   end

   initial begin
      pace_mode            = PACE_FULL;
      sample_taken         = 1'b0;
      cycle_count          = 0;
      failures             = 0;
      scan_pos             = 0;
      col_cnt              = '0;
      row_cnt              = '0;
      vert_idx             = '0;
      for (int i = 0; i < GridDim; i++) begin
         above_row[i]  = '0;
         center_row[i] = '0;
      end
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.column_height = '0;
      req_if.new_part      = 1'b0;
      rsp_if.ready         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Four border samples at both height extremes, then a restart in the middle
      // of the row and a tall checker relief that runs into the first interior row.
      add_sample(MaxHeight, 1'b1);
      add_sample('0, 1'b0);
      add_sample(MaxHeight, 1'b0);
      add_sample('0, 1'b0);
      add_scan(RELIEF_CHECKER, 0, 2 * GridDim + 8, 1'b1);
      scan_pos = 2 * GridDim + 8;
      while (sample_queue.size() != 0 || face_queue.size() != 0) @(posedge clock);

      // The scan continues through the other pacing phases without a restart.
      for (int p = int'(PACE_SRC_GAPS); p <= int'(PACE_BOTH); p++) begin
         pace_mode = pace_mode_type'(p);
         add_scan(RELIEF_RANDOM, scan_pos, PhaseItems, 1'b0);
         scan_pos = scan_pos + PhaseItems;
         while (sample_queue.size() != 0 || face_queue.size() != 0) @(posedge clock);
      end

      repeat (DrainCycles) @(posedge clock);
      if (failures == 0 && face_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
